@@ sv/float_to_base90_text_encoder_top_macros.svh @@
// ----------------------------------------------------------------------------
// float_to_base90_text_encoder_top_macros
// assertion helpers shared by the encoder modules
// ----------------------------------------------------------------------------
`ifndef FLOAT_TO_BASE90_TEXT_ENCODER_TOP_MACROS_SVH
`define FLOAT_TO_BASE90_TEXT_ENCODER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define F2B90_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("f2b90 assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define F2B90_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("f2b90 assertion failed");

`endif

@@ sv/f2b90_pkg.sv @@
// ----------------------------------------------------------------------------
// f2b90_pkg
// types, constants and helpers for the base-90 float text encoder
// ----------------------------------------------------------------------------
package f2b90_pkg;

	localparam int LINE_W = 4;

	// clamp limits as single-precision magnitude patterns
	localparam logic [30:0] MAG_BIG   = 31'h6E013F39;
	localparam logic [30:0] MAG_SMALL = 31'h10FD87B6;

	localparam int FRAC_STEP    = 729000;
	localparam int DIGIT_MAX_D4 = 11;
	localparam logic [6:0] ZERO_TOP   = 7'd80;
	localparam logic [6:0] SIGN_ADD   = 7'd40;
	localparam logic [6:0] HI_WEIGHT  = 7'd12;
	localparam logic [7:0] CHAR_BASE  = 8'd33;
	localparam logic [7:0] CHAR_SKIP0 = 8'd94;
	localparam logic [7:0] CHAR_SKIP1 = 8'd123;

	// exact reciprocals for the remainder range below 729000
	localparam int RECIP_SH_8100 = 33;
	localparam int RECIP_SH_90   = 27;
	localparam logic [20:0] RECIP_8100 =
		21'(((64'd1 << RECIP_SH_8100) + 64'd8099) / 64'd8100);
	localparam logic [20:0] RECIP_90 =
		21'(((64'd1 << RECIP_SH_90) + 64'd89) / 64'd90);

	// classified item, front to back
	typedef struct packed {
		logic        zero;
		logic        neg;
		logic [30:0] mag;
		logic        nl;
	} cls_t;

	typedef struct packed {
		logic [6:0]  d3;
		logic [6:0]  top;
		logic [19:0] rem1;
		logic        nl;
	} s2_t;

	typedef struct packed {
		logic [6:0]  d3;
		logic [6:0]  top;
		logic [6:0]  d2;
		logic [12:0] q90;
		logic [19:0] rem1;
		logic        nl;
	} s3_t;

	// queue status seen by the back end
	typedef struct packed {
		logic empty;
		cls_t head;
	} qstat_t;

	// digit to printable character, skipping caret and open brace
	function automatic logic [6:0] enc_char(input logic [6:0] digit);
		logic [7:0] c;
		c = {1'b0, digit} + CHAR_BASE;
		if (c >= CHAR_SKIP0) c = c + 8'd1;
		if (c >= CHAR_SKIP1) c = c + 8'd1;
		return c[6:0];
	endfunction

endpackage

@@ sv/f2b90_front.sv @@
// ----------------------------------------------------------------------------
// f2b90_front
// accepts values, clamps and classifies them, tracks the line position
// ----------------------------------------------------------------------------
module f2b90_front #(
	parameter int VALUES_PER_LINE = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [31:0]           value_bits,
	input  logic                  end_of_row,
	input  logic                  q_full,
	output logic                  q_wr,
	output f2b90_pkg::cls_t       q_wdata
);

	logic                          v_s1;
	f2b90_pkg::cls_t               cls_s1;
	logic [f2b90_pkg::LINE_W-1:0]  line_q;
	logic                          acc;
	logic                          nl;
	logic [f2b90_pkg::LINE_W:0]    line_inc;
	logic [30:0]                   mag;

	assign full    = v_s1 && q_full;
	assign acc     = push && !full;
	assign q_wr    = v_s1 && !q_full;
	assign q_wdata = cls_s1;

	assign line_inc = {1'b0, line_q} + (f2b90_pkg::LINE_W+1)'(1);
	assign nl = (line_inc >= (f2b90_pkg::LINE_W+1)'(VALUES_PER_LINE)) || end_of_row;

	always_comb begin
		mag = value_bits[30:0];
		if (mag > f2b90_pkg::MAG_BIG) mag = f2b90_pkg::MAG_BIG;
		if (mag < f2b90_pkg::MAG_SMALL) mag = f2b90_pkg::MAG_SMALL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			line_q <= '0;
		end else begin
			if (acc) begin
				v_s1   <= 1'b1;
				line_q <= nl ? '0 : line_inc[f2b90_pkg::LINE_W-1:0];
			end else if (q_wr) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cls_s1.zero <= (value_bits[30:0] == 31'd0);
			cls_s1.neg  <= value_bits[31];
			cls_s1.mag  <= mag;
			cls_s1.nl   <= nl;
		end
	end

`include "float_to_base90_text_encoder_top_macros.svh"

	`F2B90_ASSERT_NEXT(a_load_valid, acc, v_s1)
	`F2B90_ASSERT_IMPL(a_line_range, 1'b1, line_inc <= (f2b90_pkg::LINE_W+1)'(VALUES_PER_LINE))
	`F2B90_ASSERT_IMPL(a_stall_holds, v_s1 && !q_wr, full)

endmodule

@@ sv/f2b90_queue.sv @@
// ----------------------------------------------------------------------------
// f2b90_queue
// short register queue between the front and back ends
// ----------------------------------------------------------------------------
module f2b90_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr,
	input  f2b90_pkg::cls_t       wdata,
	output logic                  full,
	input  logic                  rd,
	output f2b90_pkg::qstat_t     stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	f2b90_pkg::cls_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign full       = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.head  = mem_q[rd_ptr_q];
	assign do_wr      = wr && !full;
	assign do_rd      = rd && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd) rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd) count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wdata;
	end

`include "float_to_base90_text_encoder_top_macros.svh"

	`F2B90_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(DEPTH))
	`F2B90_ASSERT_NEXT(a_count_up, do_wr && !do_rd, count_q != '0)

endmodule

@@ sv/f2b90_back.sv @@
// ----------------------------------------------------------------------------
// f2b90_back
// digit split pipeline and output register of the encoder
// ----------------------------------------------------------------------------
module f2b90_back (
	input  logic               clk,
	input  logic               arst_n,
	input  f2b90_pkg::qstat_t  qstat,
	output logic               q_rd,
	output logic               empty,
	input  logic               pop,
	output logic [6:0]         char0,
	output logic [6:0]         char1,
	output logic [6:0]         char2,
	output logic [6:0]         char3,
	output logic [6:0]         char4,
	output logic               newline_after
);

	logic            v_s2, v_s3, v_s4;
	logic            rdy2, rdy3, rdy4;
	f2b90_pkg::s2_t  st_s2;
	f2b90_pkg::s3_t  st_s3;
	f2b90_pkg::s2_t  nx2;
	f2b90_pkg::s3_t  nx3;
	logic [7:0]      lnx;
	logic [1:0]      hi;
	logic [22:0]     frac;
	logic [3:0]      d4;
	logic [40:0]     prod_d2;
	logic [40:0]     prod_q90;
	logic [19:0]     d0_w;
	logic [12:0]     d1_w;

	assign rdy4  = !v_s4 || pop;
	assign rdy3  = !v_s3 || rdy4;
	assign rdy2  = !v_s2 || rdy3;
	assign q_rd  = !qstat.empty && rdy2;
	assign empty = !v_s4;

	// exponent split and top fraction digit
	always_comb begin
		lnx  = qstat.head.mag[30:23] + 8'd2;
		frac = qstat.head.mag[22:0];
		hi   = 2'd0;
		if (lnx >= 8'd180) hi = 2'd2;
		else if (lnx >= 8'd90) hi = 2'd1;
		d4 = '0;
		for (int k = 1; k <= f2b90_pkg::DIGIT_MAX_D4; k++) begin
			if (frac >= 23'(k * f2b90_pkg::FRAC_STEP)) d4 = 4'(k);
		end
		nx2.rem1 = 20'(frac - 23'(d4) * 23'(f2b90_pkg::FRAC_STEP));
		nx2.d3   = 7'(lnx - 8'(hi) * 8'd90);
		nx2.top  = 7'(d4) + 7'(hi) * f2b90_pkg::HI_WEIGHT
			+ (qstat.head.neg ? f2b90_pkg::SIGN_ADD : 7'd0);
		nx2.nl   = qstat.head.nl;
		if (qstat.head.zero) begin
			nx2.rem1 = '0;
			nx2.d3   = '0;
			nx2.top  = f2b90_pkg::ZERO_TOP;
		end
	end

	// reciprocal products for the middle digits
	always_comb begin
		prod_d2  = 41'(st_s2.rem1) * 41'(f2b90_pkg::RECIP_8100);
		prod_q90 = 41'(st_s2.rem1) * 41'(f2b90_pkg::RECIP_90);
		nx3.d3   = st_s2.d3;
		nx3.top  = st_s2.top;
		nx3.rem1 = st_s2.rem1;
		nx3.nl   = st_s2.nl;
		nx3.d2   = prod_d2[f2b90_pkg::RECIP_SH_8100 +: 7];
		nx3.q90  = prod_q90[f2b90_pkg::RECIP_SH_90 +: 13];
	end

	assign d1_w = st_s3.q90 - 13'(st_s3.d2) * 13'd90;
	assign d0_w = st_s3.rem1 - 20'(st_s3.q90) * 20'd90;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy2) v_s2 <= q_rd;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) st_s2 <= nx2;
		if (rdy3 && v_s2) st_s3 <= nx3;
		if (rdy4 && v_s3) begin
			char0         <= f2b90_pkg::enc_char(d0_w[6:0]);
			char1         <= f2b90_pkg::enc_char(d1_w[6:0]);
			char2         <= f2b90_pkg::enc_char(st_s3.d2);
			char3         <= f2b90_pkg::enc_char(st_s3.d3);
			char4         <= f2b90_pkg::enc_char(st_s3.top);
			newline_after <= st_s3.nl;
		end
	end

`include "float_to_base90_text_encoder_top_macros.svh"

	`F2B90_ASSERT_IMPL(a_char4_legal, v_s4, char4 != 7'd94 && char4 != 7'd123)
	`F2B90_ASSERT_IMPL(a_digits_small, v_s3, d1_w < 13'd90 && d0_w < 20'd90)
	`F2B90_ASSERT_NEXT(a_pop_drains, pop && v_s4 && !v_s3, !v_s4)

endmodule

@@ sv/float_to_base90_text_encoder_top.sv @@
// ----------------------------------------------------------------------------
// float_to_base90_text_encoder_top
// path: an accepted item goes through the front register, the queue, the
// split and reciprocal stages into the output register (empty low)
// throughput: one item per cycle while popped; digit split fully pipelined
// reset: arst_n clears the line position, the queue and all valid flags
// ----------------------------------------------------------------------------
module float_to_base90_text_encoder_top #(
	parameter int VALUES_PER_LINE = 15,
	parameter int QUEUE_DEPTH     = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// input queue side
	input  logic        push,
	output logic        full,
	input  logic [31:0] value_bits,
	input  logic        end_of_row,
	// result queue side
	output logic        empty,
	input  logic        pop,
	output logic [6:0]  char0,
	output logic [6:0]  char1,
	output logic [6:0]  char2,
	output logic [6:0]  char3,
	output logic [6:0]  char4,
	output logic        newline_after
);

	// front to queue
	logic              q_wr;
	logic              q_full;
	f2b90_pkg::cls_t   q_wdata;
	// queue to back
	logic              q_rd;
	f2b90_pkg::qstat_t q_stat;

	// front end: clamps the magnitude into [1e-28, 1e28], flags zero and sign,
	// and decides the newline flag in arrival order, so the line counter
	// never has to see the back end
	f2b90_front #(
		.VALUES_PER_LINE(VALUES_PER_LINE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.value_bits (value_bits),
		.end_of_row (end_of_row),
		.q_full     (q_full),
		.q_wr       (q_wr),
		.q_wdata    (q_wdata)
	);

	// short queue so a stalled consumer does not immediately stop the front
	f2b90_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.stat   (q_stat)
	);

	// back end: exponent split and top digit, then reciprocal multiplies for
	// the weight 8100 and 90 digits, then remainders and character mapping
	// into the output register that forms the result queue head
	f2b90_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qstat         (q_stat),
		.q_rd          (q_rd),
		.empty         (empty),
		.pop           (pop),
		.char0         (char0),
		.char1         (char1),
		.char2         (char2),
		.char3         (char3),
		.char4         (char4),
		.newline_after (newline_after)
	);

endmodule

@@ tb/tb_float_to_base90_text_encoder_top.sv @@
// ----------------------------------------------------------------------------
// tb_float_to_base90_text_encoder_top
// self-checking bench for the base-90 float text encoder: a directed table of
// zeros, clamps, infinities, NaNs, skipped chars and line breaks, a squeeze
// on a stalled output, a long random stream in bursts; each popped group is
// checked field by field against pins or the bench encoder and line counter
// ----------------------------------------------------------------------------
module tb_float_to_base90_text_encoder_top;

	// encoding constants
	localparam int LINE_LEN     = 15;
	localparam int DIGIT_BASE   = 90;
	localparam int W_MID        = 8100;
	localparam int W_TOP        = 729000;
	localparam int EXP_OFFSET   = 2;
	localparam int HI_STEP      = 12;
	localparam int SIGN_STEP    = 40;
	localparam int ZERO_DIGIT   = 80;
	localparam int GLYPH_BASE   = 33;
	localparam int GLYPH_SKIP_A = 94;
	localparam int GLYPH_SKIP_B = 123;

	// run shape
	localparam int RANDOM_ITEMS = 1250;
	localparam int HOLD_CYCLES  = 64;
	localparam int SQUEEZE_ITEMS = 32;
	localparam int DRAIN_CYCLES = 10;
	localparam int STALL_LIMIT  = 3000;

	// one group of five characters and its line break flag
	typedef struct packed {
		logic [6:0] c0;
		logic [6:0] c1;
		logic [6:0] c2;
		logic [6:0] c3;
		logic [6:0] c4;
		logic       nl;
	} glyphs_t;

	// directed row: value, row end, and optionally the characters typed in
	typedef struct packed {
		logic [31:0] bits;
		logic        eor;
		logic        pinned;
		glyphs_t     pins;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [31:0] value_bits = 32'h0;
	logic        end_of_row = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [6:0]  char0;
	logic [6:0]  char1;
	logic [6:0]  char2;
	logic [6:0]  char3;
	logic [6:0]  char4;
	logic        newline_after;

	// expected groups, oldest first
	glyphs_t pending_glyphs[$];
	int      col_count = 0;
	int      mismatch_count = 0;
	int      groups_seen = 0;
	int      idle_cycles = 0;
	bit      hold_req = 1'b0;

	// pinned characters of the item currently on the input
	bit      cur_pinned = 1'b0;
	glyphs_t cur_pins = '0;

	// zeros, clamp edges, infinities, NaNs, exponent wrap points, skipped chars
	row_t dir_rows[23] = '{
		'{32'h00000000, 1'b0, 1'b1, '{7'd33, 7'd33, 7'd33, 7'd33, 7'd114, 1'b0}},
		'{32'h80000000, 1'b0, 1'b1, '{7'd33, 7'd33, 7'd33, 7'd33, 7'd114, 1'b0}},
		'{32'h7F800000, 1'b0, 1'b1, '{7'd34, 7'd41, 7'd43, 7'd75, 7'd57, 1'b0}},
		'{32'hFF800000, 1'b0, 1'b1, '{7'd34, 7'd41, 7'd43, 7'd75, 7'd98, 1'b0}},
		'{32'h6E013F39, 1'b0, 1'b1, '{7'd34, 7'd41, 7'd43, 7'd75, 7'd57, 1'b0}},
		'{32'h7FC00000, 1'b0, 1'b1, '{7'd34, 7'd41, 7'd43, 7'd75, 7'd57, 1'b0}},
		'{32'hFFFFFFFF, 1'b1, 1'b1, '{7'd34, 7'd41, 7'd43, 7'd75, 7'd98, 1'b0}},
		'{32'h6E013F3A, 1'b0, 1'b0, '0},
		'{32'h10FD87B6, 1'b0, 1'b0, '0},
		'{32'h10FD87B5, 1'b0, 1'b0, '0},
		'{32'h00000001, 1'b0, 1'b0, '0},
		'{32'h807FFFFF, 1'b0, 1'b0, '0},
		'{32'h3F800000, 1'b0, 1'b0, '0},
		'{32'h3F000000, 1'b0, 1'b0, '0},
		'{32'hBF800000, 1'b1, 1'b0, '0},
		'{32'h2B800000, 1'b0, 1'b0, '0},
		'{32'h2C000000, 1'b0, 1'b0, '0},
		'{32'h59000000, 1'b0, 1'b0, '0},
		'{32'h3F80003C, 1'b0, 1'b0, '0},
		'{32'h3F80003D, 1'b0, 1'b0, '0},
		'{32'h3F800059, 1'b0, 1'b0, '0},
		'{32'h1D800000, 1'b0, 1'b0, '0},
		'{32'h3FFFFFFF, 1'b1, 1'b0, '0}
	};

	float_to_base90_text_encoder_top #(
		.VALUES_PER_LINE(LINE_LEN)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.value_bits   (value_bits),
		.end_of_row   (end_of_row),
		.empty        (empty),
		.pop          (pop),
		.char0        (char0),
		.char1        (char1),
		.char2        (char2),
		.char3        (char3),
		.char4        (char4),
		.newline_after(newline_after)
	);

	always #6 clk = ~clk;

	// digit to printable character, stepping over caret and open brace
	function automatic logic [6:0] glyph_of(input int digit);
		int c;
		c = digit + GLYPH_BASE;
		if (c >= GLYPH_SKIP_A) c++;
		if (c >= GLYPH_SKIP_B) c++;
		return 7'(c);
	endfunction

	// expected group for one value; advances the line counter
	function automatic glyphs_t encode_float(input logic [31:0] bits, input logic eor);
		glyphs_t     g;
		logic [30:0] mag;
		int          lnx;
		int          hi;
		int          frac;
		int          d0;
		int          d1;
		int          d2;
		int          d3;
		int          d4;
		mag = bits[30:0];
		if (mag == 31'd0) begin
			// both zeros: top digit only
			d0 = 0;
			d1 = 0;
			d2 = 0;
			d3 = 0;
			d4 = ZERO_DIGIT;
		end else begin
			// clamp magnitude, infinities and NaNs fall on the upper limit
			if (mag > f2b90_pkg::MAG_BIG) mag = f2b90_pkg::MAG_BIG;
			if (mag < f2b90_pkg::MAG_SMALL) mag = f2b90_pkg::MAG_SMALL;
			lnx = int'(mag[30:23]) + EXP_OFFSET;
			hi = lnx / DIGIT_BASE;
			d3 = lnx % DIGIT_BASE;
			frac = int'(mag[22:0]);
			d4 = frac / W_TOP;
			frac = frac % W_TOP;
			d2 = frac / W_MID;
			frac = frac % W_MID;
			d1 = frac / DIGIT_BASE;
			d0 = frac % DIGIT_BASE;
			d4 = d4 + hi * HI_STEP + (bits[31] ? SIGN_STEP : 0);
		end
		g.c0 = glyph_of(d0);
		g.c1 = glyph_of(d1);
		g.c2 = glyph_of(d2);
		g.c3 = glyph_of(d3);
		g.c4 = glyph_of(d4);
		// a full line or a row end both break, once
		if (col_count + 1 >= LINE_LEN || eor) begin
			g.nl = 1'b1;
			col_count = 0;
		end else begin
			g.nl = 1'b0;
			col_count++;
		end
		return g;
	endfunction

	function automatic int pick_digit();
		case ($urandom_range(0, 4))
			0: return 60;
			1: return 61;
			2: return 89;
			3: return 0;
			default: return $urandom_range(0, DIGIT_BASE - 1);
		endcase
	endfunction

	// random value aimed at the interesting regions of the encoding
	function automatic logic [31:0] random_value();
		logic        s;
		int          frac;
		s = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom();
			3: return {s, 8'($urandom_range(34, 219)), 23'($urandom())};
			4: return {s, 31'd0};
			5: return {s, 8'hFF, ($urandom_range(0, 1) ? 23'd0 : 23'($urandom()))};
			6: return {s, 8'($urandom_range(0, 33)), 23'($urandom())};
			7: return {s, 8'($urandom_range(220, 254)), 23'($urandom())};
			8: return {s, 8'($urandom()), 23'd0};
			default: begin
				// digits near the skipped characters
				frac = $urandom_range(0, 10) * W_TOP;
				frac += pick_digit() * W_MID;
				frac += pick_digit() * DIGIT_BASE;
				frac += pick_digit();
				return {s, 8'($urandom_range(34, 219)), 23'(frac)};
			end
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("[%0t] group %0d %s: got %0d, expected %0d",
			$time, groups_seen, what, got, want);
		mismatch_count++;
	endtask

	// put one item on the input and hold it until it is taken
	task automatic offer_item(input logic [31:0] bits, input logic eor,
		input bit pinned, input glyphs_t pins);
		@(negedge clk);
		push <= 1'b1;
		value_bits <= bits;
		end_of_row <= eor;
		cur_pinned = pinned;
		cur_pins = pins;
		do @(posedge clk); while (full);
	endtask

	// input idle, with noise on the data lines
	task automatic rest_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			push <= 1'b0;
			value_bits <= $urandom();
			end_of_row <= 1'($urandom_range(0, 1));
		end
	endtask

	// scoreboard and watchdog, all on the rising edge
	always @(posedge clk) begin : result_check
		glyphs_t want;
		bit      moved;
		moved = 1'b0;
		if (arst_n) begin
			// result side first; a group can never leave in its own push cycle
			if (pop && !empty) begin
				moved = 1'b1;
				if (pending_glyphs.size() == 0) begin
					flag_mismatch("result with no item pending, char0", char0, -1);
				end else begin
					want = pending_glyphs.pop_front();
					if (char0 !== want.c0) flag_mismatch("char0", char0, want.c0);
					if (char1 !== want.c1) flag_mismatch("char1", char1, want.c1);
					if (char2 !== want.c2) flag_mismatch("char2", char2, want.c2);
					if (char3 !== want.c3) flag_mismatch("char3", char3, want.c3);
					if (char4 !== want.c4) flag_mismatch("char4", char4, want.c4);
					if (newline_after !== want.nl)
						flag_mismatch("newline_after", newline_after, want.nl);
				end
				groups_seen++;
			end
			// input side: predict at the accepting edge
			if (push && !full) begin
				moved = 1'b1;
				want = encode_float(value_bits, end_of_row);
				if (cur_pinned) begin
					// typed-in characters, line flag still from the counter
					want.c0 = cur_pins.c0;
					want.c1 = cur_pins.c1;
					want.c2 = cur_pins.c2;
					want.c3 = cur_pins.c3;
					want.c4 = cur_pins.c4;
				end
				pending_glyphs.push_back(want);
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("** float_to_base90_text_encoder_top: FAILED **");
				$finish;
			end
		end
	end

	// result side: modes of random length, plus one long hold-off on request
	initial begin : pop_pattern
		int mode;
		int span;
		int k;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 96);
			for (k = 0; k < span; k++) begin
				@(negedge clk);
				if (hold_req) begin
					// long stall so the block fills and raises full
					hold_req = 1'b0;
					pop <= 1'b0;
					repeat (HOLD_CYCLES - 1) @(negedge clk);
				end else begin
					case (mode)
						0: pop <= 1'b1;
						1: pop <= 1'($urandom_range(0, 1));
						2: pop <= (k % 4 == 0);
						default: pop <= ($urandom_range(0, 9) != 0);
					endcase
				end
			end
		end
	end

	// stimulus
	initial begin : feed
		int sent;
		int burst;
		int gap;
		int k;

		// reset, once
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (dir_rows[i]) begin
			offer_item(dir_rows[i].bits, dir_rows[i].eor, dir_rows[i].pinned,
				dir_rows[i].pins);
			if ($urandom_range(0, 3) == 0) rest_cycles(1);
		end

		// back-to-back items against a stalled output, so that full pushes back
		hold_req = 1'b1;
		repeat (SQUEEZE_ITEMS)
			offer_item(random_value(), ($urandom_range(0, 7) == 0), 1'b0, '0);

		// pause until everything so far has come out
		rest_cycles(1);
		while (pending_glyphs.size() != 0) @(posedge clk);

		// random stream in bursts, some bursts with no gap after them
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 40);
			for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				offer_item(random_value(), ($urandom_range(0, 7) == 0), 1'b0, '0);
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) rest_cycles(gap);
		end

		// drain, then a few more cycles for stray results
		rest_cycles(1);
		while (pending_glyphs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("** float_to_base90_text_encoder_top: PASSED **");
		else
			$display("** float_to_base90_text_encoder_top: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/f2b90_pkg.sv
sv/f2b90_front.sv
sv/f2b90_queue.sv
sv/f2b90_back.sv
sv/float_to_base90_text_encoder_top.sv
tb/tb_float_to_base90_text_encoder_top.sv
